### hw/rtl/jdtp_pkg.sv
// jdtp_pkg: shared types, register indexes and layout constants for the
// journal descriptor tag parser. No dependencies.

package jdtp_pkg;

    // field and register widths
    localparam int BYTE_W      = 8;
    localparam int WORD_W      = 32;
    localparam int FSB_W       = 64;
    localparam int POS_W       = 13;
    localparam int KIND_W      = 3;
    localparam int BLK_CFG_W   = 17;
    localparam int TAG_CFG_W   = 5;
    localparam int CFG_ADDR_W  = 5;

    localparam int DEF_MAX_BLOCK_BYTES = 65536;

    // block layout
    localparam int HEADER_BYTES      = 12;
    localparam int TAIL_BYTES        = 4;
    localparam int UUID_BYTES        = 16;
    localparam int V3_TAG_BYTES      = 16;
    localparam int CLASSIC_TAG_BYTES = 12;
    localparam int SHORT_TAG_BYTES   = 8;
    localparam int MAGIC_END_OFF     = 3;
    localparam int TYPE_END_OFF      = 7;
    localparam int LOW_WORD_END      = 3;
    localparam int FLAGS_END         = 7;
    localparam int HIGH_WORD_END     = 11;

    localparam logic [WORD_W-1:0] SAME_UUID_FLAG = 32'h0000_0002;
    localparam logic [WORD_W-1:0] LAST_TAG_FLAG  = 32'h0000_0008;

    // register reset values
    localparam logic [BLK_CFG_W-1:0] RST_BLOCK_BYTES = 17'd4096;
    localparam logic [TAG_CFG_W-1:0] RST_TAG_BYTES   = 5'd12;
    localparam logic [WORD_W-1:0]    RST_MAGIC       = 32'hC03B_3998;
    localparam logic [WORD_W-1:0]    RST_DESC_TYPE   = 32'h0000_0001;

    // result word queue
    localparam int RES_FIFO_DEPTH = 4;

    typedef enum logic [KIND_W-1:0] {
        KIND_TAG       = 3'd0,
        KIND_DONE      = 3'd1,
        KIND_SMALL     = 3'd2,
        KIND_BAD_MAGIC = 3'd3,
        KIND_NOT_DESC  = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        REG_BLOCK_BYTES = 3'd0,
        REG_TAG_BYTES   = 3'd1,
        REG_HAS_TAIL    = 3'd2,
        REG_MAGIC       = 3'd3,
        REG_DESC_TYPE   = 3'd4
    } reg_idx_t;

    typedef struct packed {
        kind_t              kind;
        logic [FSB_W-1:0]   fs_block;
        logic [POS_W-1:0]   tag_position;
        logic               last_result;
    } result_t;

endpackage

### hw/rtl/jdtp_if.sv
// jdtp_if: valid/ready channel interfaces for input byte words and result words.
// Depends on jdtp_pkg.

interface jdtp_byte_if;
    import jdtp_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface jdtp_result_if;
    import jdtp_pkg::*;

    logic              valid;
    logic              ready;
    kind_t             kind;
    logic [FSB_W-1:0]  fs_block;
    logic [POS_W-1:0]  tag_position;
    logic              last_result;

    modport source (output valid, output kind, output fs_block, output tag_position,
                     output last_result, input ready);
    modport sink   (input valid, input kind, input fs_block, input tag_position,
                    input last_result, output ready);
endinterface

### hw/rtl/journal_descriptor_tag_parser_core.sv
// journal_descriptor_tag_parser_core: byte-serial parser for journal descriptor
// blocks with an APB register port. Depends on jdtp_pkg and jdtp_if.
//
// Usage: the bytes of one descriptor block stream in on the bytes channel, one
// word per byte, in block order. Block size, tag size, tail flag, magic and
// type are set over the APB port; the user must set them only while the
// parser is idle, the block does not enforce this. Each accepted byte is
// decoded in the cycle it is accepted and its results (none, one or two) are
// written into a four-entry result queue that drives the results channel. One
// result word comes out per tag taken, plus a done word with the tag count on
// the final byte, or a single error word (block too small, bad magic, not a
// descriptor) after which the rest of the block is absorbed. A result enters
// the queue when its byte is accepted. Throughput: one byte per cycle while
// bytes is ready, set by the combinational offset compare and tag decode;
// bytes is ready whenever the queue has room for two words.
// Stall: when the receiver holds results.ready low the queue fills and bytes
// drops ready; nothing is lost. Reset clears the registers to their defaults,
// empties the queue and starts at offset zero of a new block.

module journal_descriptor_tag_parser_core #(
    parameter int MAX_BLOCK_BYTES = jdtp_pkg::DEF_MAX_BLOCK_BYTES
) (
    input  logic                            clk,
    input  logic                            rst_n,
    jdtp_byte_if.sink                       bytes,
    jdtp_result_if.source                   results,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [jdtp_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [jdtp_pkg::WORD_W-1:0]     pwdata,
    output logic [jdtp_pkg::WORD_W-1:0]     prdata,
    output logic                            pready
);
    import jdtp_pkg::*;

    localparam int OFF_W = $clog2(MAX_BLOCK_BYTES + 1);
    localparam int NTO_W = OFF_W + 1;
    localparam int PTR_W = $clog2(RES_FIFO_DEPTH);
    localparam int CNT_W = $clog2(RES_FIFO_DEPTH + 1);

    // configuration registers
    logic [BLK_CFG_W-1:0] block_bytes_reg;
    logic [TAG_CFG_W-1:0] tag_bytes_reg;
    logic                 has_tail_reg;
    logic [WORD_W-1:0]    magic_reg;
    logic [WORD_W-1:0]    desc_type_reg;
    logic                 cfg_wr;

    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_bytes_reg <= RST_BLOCK_BYTES;
            tag_bytes_reg   <= RST_TAG_BYTES;
            has_tail_reg    <= 1'b0;
            magic_reg       <= RST_MAGIC;
            desc_type_reg   <= RST_DESC_TYPE;
        end
        else if (cfg_wr)
        begin
            case (reg_idx_t'(paddr[4:2]))
                REG_BLOCK_BYTES: block_bytes_reg <= pwdata[BLK_CFG_W-1:0];
                REG_TAG_BYTES:   tag_bytes_reg   <= pwdata[TAG_CFG_W-1:0];
                REG_HAS_TAIL:    has_tail_reg    <= pwdata[0];
                REG_MAGIC:       magic_reg       <= pwdata;
                REG_DESC_TYPE:   desc_type_reg   <= pwdata;
                default:         ;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        case (reg_idx_t'(paddr[4:2]))
            REG_BLOCK_BYTES: prdata = WORD_W'(block_bytes_reg);
            REG_TAG_BYTES:   prdata = WORD_W'(tag_bytes_reg);
            REG_HAS_TAIL:    prdata = WORD_W'(has_tail_reg);
            REG_MAGIC:       prdata = magic_reg;
            REG_DESC_TYPE:   prdata = desc_type_reg;
            default:         prdata = '0;
        endcase
    end

    // parser state
    logic [OFF_W-1:0]  offset_reg, offset_next;
    logic [NTO_W-1:0]  nto_reg, nto_next;
    logic              stopped_reg, stopped_next;
    logic              failed_reg, failed_next;
    logic [POS_W-1:0]  tags_reg, tags_next;
    logic [WORD_W-1:0] word_shift_reg, word_shift_next;
    logic [WORD_W-1:0] low_word_reg, low_word_next;
    logic [WORD_W-1:0] flags_reg, flags_next;

    // effective configuration
    logic [NTO_W-1:0] blk_eff;
    logic [NTO_W-1:0] tb;
    logic [NTO_W-1:0] tail;
    logic [NTO_W-1:0] limit;
    logic             is_v3;
    logic             is_short;

    always_comb
    begin
        if (block_bytes_reg == '0)
            blk_eff = NTO_W'(1);
        else if (block_bytes_reg > BLK_CFG_W'(MAX_BLOCK_BYTES))
            blk_eff = NTO_W'(MAX_BLOCK_BYTES);
        else
            blk_eff = NTO_W'(block_bytes_reg);

        is_v3    = (tag_bytes_reg == TAG_CFG_W'(V3_TAG_BYTES));
        is_short = !is_v3 && (tag_bytes_reg <= TAG_CFG_W'(SHORT_TAG_BYTES));
        if (is_v3)
            tb = NTO_W'(V3_TAG_BYTES);
        else if (is_short)
            tb = NTO_W'(SHORT_TAG_BYTES);
        else
            tb = NTO_W'(CLASSIC_TAG_BYTES);

        tail  = has_tail_reg ? NTO_W'(TAIL_BYTES) : '0;
        limit = (blk_eff > tail) ? (blk_eff - tail) : '0;
    end

    // byte decode
    logic             acc;
    logic [NTO_W-1:0] off_ext;
    logic [NTO_W-1:0] rel;
    logic             final_byte;
    logic             too_small, bad_magic, bad_type, err_now;
    logic             in_tag, at_low, at_flags, emit, done;
    logic [WORD_W-1:0] flags_now;
    logic [NTO_W-1:0] stride;
    logic [POS_W-1:0] pos_inc;
    logic [POS_W-1:0] tags_after;
    kind_t            err_kind;
    result_t          res_a, res_b;
    logic             push_a, push_b;

    assign acc     = bytes.valid && bytes.ready;
    assign off_ext = NTO_W'(offset_reg);
    assign rel     = off_ext - nto_reg;

    always_comb
    begin
        word_shift_next = {word_shift_reg[WORD_W-BYTE_W-1:0], bytes.data_byte};
        final_byte      = (off_ext + NTO_W'(1)) >= blk_eff;

        too_small = (offset_reg == '0) && (blk_eff < NTO_W'(HEADER_BYTES) + tb);
        bad_magic = (offset_reg == OFF_W'(MAGIC_END_OFF)) && (word_shift_next != magic_reg);
        bad_type  = (offset_reg == OFF_W'(TYPE_END_OFF)) && (word_shift_next != desc_type_reg);
        err_now   = !failed_reg && (too_small || bad_magic || bad_type);

        if (too_small)
            err_kind = KIND_SMALL;
        else if (bad_magic)
            err_kind = KIND_BAD_MAGIC;
        else
            err_kind = KIND_NOT_DESC;

        in_tag   = !failed_reg && !err_now && !stopped_reg && (off_ext >= nto_reg)
                   && ((nto_reg + tb) <= limit);
        at_low   = in_tag && (rel == NTO_W'(LOW_WORD_END));
        at_flags = in_tag && (rel == NTO_W'(FLAGS_END));
        emit     = in_tag && (rel == (is_short ? NTO_W'(FLAGS_END) : NTO_W'(HIGH_WORD_END)));

        // flags word seen by this byte, including one that completes here
        if (at_flags)
            flags_now = is_v3 ? word_shift_next : {16'h0000, word_shift_next[15:0]};
        else
            flags_now = flags_reg;

        stride     = tb + (((flags_now & SAME_UUID_FLAG) != '0) ? '0 : NTO_W'(UUID_BYTES));
        pos_inc    = tags_reg + POS_W'(1);
        tags_after = emit ? pos_inc : tags_reg;
        done       = final_byte && !failed_reg && !err_now;

        // first and second result words of this byte
        res_b.kind         = KIND_DONE;
        res_b.fs_block     = '0;
        res_b.tag_position = tags_after;
        res_b.last_result  = 1'b1;
        if (err_now)
        begin
            res_a.kind         = err_kind;
            res_a.fs_block     = '0;
            res_a.tag_position = '0;
            res_a.last_result  = 1'b1;
        end
        else if (emit)
        begin
            res_a.kind         = KIND_TAG;
            res_a.fs_block     = {(is_short ? '0 : word_shift_next), low_word_reg};
            res_a.tag_position = pos_inc;
            res_a.last_result  = 1'b0;
        end
        else
        begin
            res_a = res_b;
        end

        push_a = acc && (err_now || emit || done);
        push_b = acc && emit && done;
    end

    // next parser state
    always_comb
    begin
        offset_next   = offset_reg;
        nto_next      = nto_reg;
        stopped_next  = stopped_reg;
        failed_next   = failed_reg;
        tags_next     = tags_reg;
        low_word_next = low_word_reg;
        flags_next    = flags_reg;
        if (final_byte)
        begin
            offset_next   = '0;
            nto_next      = NTO_W'(HEADER_BYTES);
            stopped_next  = 1'b0;
            failed_next   = 1'b0;
            tags_next     = '0;
            low_word_next = '0;
            flags_next    = '0;
        end
        else
        begin
            offset_next = OFF_W'(off_ext + NTO_W'(1));
            failed_next = failed_reg || err_now;
            if (at_low)
                low_word_next = word_shift_next;
            if (at_flags)
                flags_next = flags_now;
            if (emit)
            begin
                tags_next = pos_inc;
                if ((flags_now & LAST_TAG_FLAG) != '0)
                    stopped_next = 1'b1;
                else
                    nto_next = nto_reg + stride;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg     <= '0;
            nto_reg        <= NTO_W'(HEADER_BYTES);
            stopped_reg    <= 1'b0;
            failed_reg     <= 1'b0;
            tags_reg       <= '0;
            word_shift_reg <= '0;
            low_word_reg   <= '0;
            flags_reg      <= '0;
        end
        else if (acc)
        begin
            offset_reg     <= offset_next;
            nto_reg        <= nto_next;
            stopped_reg    <= stopped_next;
            failed_reg     <= failed_next;
            tags_reg       <= tags_next;
            word_shift_reg <= final_byte ? '0 : word_shift_next;
            low_word_reg   <= low_word_next;
            flags_reg      <= flags_next;
        end
    end

    // result queue
    result_t           q_mem_reg [RES_FIFO_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              pop;
    result_t           head;

    assign pop         = results.valid && results.ready;
    assign bytes.ready = count_reg <= CNT_W'(RES_FIFO_DEPTH - 2);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push_a) + PTR_W'(push_b);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + CNT_W'(push_a) + CNT_W'(push_b) - CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push_a)
            q_mem_reg[wr_ptr_reg] <= res_a;
        if (push_b)
            q_mem_reg[wr_ptr_reg + PTR_W'(1)] <= res_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // output word from queue head
    assign head                 = q_mem_reg[rd_ptr_reg];
    assign results.valid        = count_reg != '0;
    assign results.kind         = head.kind;
    assign results.fs_block     = head.fs_block;
    assign results.tag_position = head.tag_position;
    assign results.last_result  = head.last_result;

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(RES_FIFO_DEPTH))
        else $error("result queue overflow");

    a_final_rewinds: assert property (@(posedge clk) disable iff (!rst_n)
        acc && final_byte |=> offset_reg == '0 && tags_reg == '0)
        else $error("block end did not rewind parser");

    a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.kind != KIND_TAG && results.kind != KIND_DONE
        |-> results.last_result)
        else $error("error word not marked last");

    a_tag_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.kind == KIND_TAG |-> !results.last_result)
        else $error("tag word marked last");

    a_no_tag_after_fail: assert property (@(posedge clk) disable iff (!rst_n)
        failed_reg |-> !emit && !done)
        else $error("output after block error");
endmodule

### test/jdtp_tag_check.sv
// jdtp_tag_check: watches the byte, result and register channels of the journal
// descriptor tag parser, predicts every result word and compares it field by field.
// Depends on jdtp_pkg.

module jdtp_tag_check #(
    parameter int MAX_BLOCK_BYTES = jdtp_pkg::DEF_MAX_BLOCK_BYTES
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            byte_valid,
    input  logic                            byte_ready,
    input  logic [jdtp_pkg::BYTE_W-1:0]     data_byte,
    input  logic                            res_valid,
    input  logic                            res_ready,
    input  jdtp_pkg::kind_t                 kind,
    input  logic [jdtp_pkg::FSB_W-1:0]      fs_block,
    input  logic [jdtp_pkg::POS_W-1:0]      tag_position,
    input  logic                            last_result,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic                            pready,
    input  logic [jdtp_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [jdtp_pkg::WORD_W-1:0]     pwdata,
    output int unsigned                     mismatches,
    output int unsigned                     outstanding
);
    import jdtp_pkg::*;

    // register copy
    logic [BLK_CFG_W-1:0] cfg_block;
    logic [TAG_CFG_W-1:0] cfg_tag;
    logic                 cfg_tail;
    logic [WORD_W-1:0]    cfg_magic;
    logic [WORD_W-1:0]    cfg_type;

    // parse state of the current block
    logic [BLK_CFG_W-1:0] cur_off;
    logic [BLK_CFG_W-1:0] tag_off;
    logic                 stopped;
    logic                 failed;
    logic [POS_W-1:0]     tag_count;
    logic [WORD_W-1:0]    shift_w;
    logic [WORD_W-1:0]    low_w;
    logic [WORD_W-1:0]    flags_w;

    result_t pending_results [$];
    result_t oldest;

    function automatic void clear_parse();
        cur_off   = '0;
        tag_off   = BLK_CFG_W'(HEADER_BYTES);
        stopped   = 1'b0;
        failed    = 1'b0;
        tag_count = '0;
        shift_w   = '0;
        low_w     = '0;
        flags_w   = '0;
    endfunction

    function automatic void queue_result(kind_t k, logic [FSB_W-1:0] blk,
                                         logic [POS_W-1:0] pos, logic last);
        result_t r;
        r.kind         = k;
        r.fs_block     = blk;
        r.tag_position = pos;
        r.last_result  = last;
        pending_results.insert(pending_results.size(), r);
    endfunction

    // one accepted byte word: advance the parse and queue what it yields
    function automatic void parse_byte(logic [BYTE_W-1:0] b);
        int unsigned blk;
        int unsigned tb;
        int unsigned tail;
        int unsigned limit;
        int unsigned rel;
        int unsigned stride;
        logic        is_last_byte;
        logic [FSB_W-1:0] fsb;

        blk = (cfg_block == 0) ? 1 : cfg_block;
        if (blk > MAX_BLOCK_BYTES)
            blk = MAX_BLOCK_BYTES;
        if (cfg_tag == V3_TAG_BYTES)
            tb = V3_TAG_BYTES;
        else if (cfg_tag > SHORT_TAG_BYTES)
            tb = CLASSIC_TAG_BYTES;
        else
            tb = SHORT_TAG_BYTES;
        tail  = cfg_tail ? TAIL_BYTES : 0;
        limit = (blk > tail) ? blk - tail : 0;
        is_last_byte = (cur_off + 1 >= blk);

        shift_w = {shift_w[WORD_W-BYTE_W-1:0], b};

        if (!failed)
        begin
            if (cur_off == 0 && blk < HEADER_BYTES + tb)
            begin
                queue_result(KIND_SMALL, '0, '0, 1'b1);
                failed = 1'b1;
            end
            else if (cur_off == MAGIC_END_OFF && shift_w != cfg_magic)
            begin
                queue_result(KIND_BAD_MAGIC, '0, '0, 1'b1);
                failed = 1'b1;
            end
            else if (cur_off == TYPE_END_OFF && shift_w != cfg_type)
            begin
                queue_result(KIND_NOT_DESC, '0, '0, 1'b1);
                failed = 1'b1;
            end
            else if (!stopped && cur_off >= tag_off && tag_off + tb <= limit)
            begin
                rel = cur_off - tag_off;
                if (rel == LOW_WORD_END)
                    low_w = shift_w;
                if (rel == FLAGS_END)
                    flags_w = (tb == V3_TAG_BYTES) ? shift_w : {16'h0, shift_w[15:0]};
                // a tag is complete once its last block-number byte is in (short tag: its last flags byte)
                if (rel == ((tb == SHORT_TAG_BYTES) ? FLAGS_END : HIGH_WORD_END))
                begin
                    fsb = {((tb == SHORT_TAG_BYTES) ? '0 : shift_w), low_w};
                    stride = tb + (((flags_w & SAME_UUID_FLAG) != 0) ? 0 : UUID_BYTES);
                    tag_count = tag_count + 1'b1;
                    queue_result(KIND_TAG, fsb, tag_count, 1'b0);
                    if ((flags_w & LAST_TAG_FLAG) != 0)
                        stopped = 1'b1;
                    else
                        tag_off = BLK_CFG_W'(tag_off + stride);
                end
            end
        end

        if (is_last_byte)
        begin
            if (!failed)
                queue_result(KIND_DONE, '0, tag_count, 1'b1);
            clear_parse();
        end
        else
            cur_off = cur_off + 1'b1;
    endfunction

    function automatic void report(string field, logic [FSB_W-1:0] want, logic [FSB_W-1:0] got);
        $display("%0t mismatch on %s: expected %0h, got %0h", $time, field, want, got);
        mismatches++;
    endfunction

    // sample all channels at the clock edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_block   = RST_BLOCK_BYTES;
            cfg_tag     = RST_TAG_BYTES;
            cfg_tail    = 1'b0;
            cfg_magic   = RST_MAGIC;
            cfg_type    = RST_DESC_TYPE;
            clear_parse();
            pending_results.delete();
            mismatches  = 0;
            outstanding = 0;
        end
        else
        begin
            // result word against the oldest prediction
            if (res_valid && res_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t unexpected result word: kind %0d block %0h position %0d last %0b",
                             $time, kind, fs_block, tag_position, last_result);
                    mismatches++;
                end
                else
                begin
                    oldest = pending_results.pop_front();
                    if (oldest.kind != kind)
                        report("kind", oldest.kind, kind);
                    if (oldest.fs_block != fs_block)
                        report("fs_block", oldest.fs_block, fs_block);
                    if (oldest.tag_position != tag_position)
                        report("tag_position", oldest.tag_position, tag_position);
                    if (oldest.last_result != last_result)
                        report("last_result", oldest.last_result, last_result);
                end
            end

            // register write
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[CFG_ADDR_W-1:2])
                    REG_BLOCK_BYTES: cfg_block = pwdata[BLK_CFG_W-1:0];
                    REG_TAG_BYTES:   cfg_tag   = pwdata[TAG_CFG_W-1:0];
                    REG_HAS_TAIL:    cfg_tail  = pwdata[0];
                    REG_MAGIC:       cfg_magic = pwdata;
                    REG_DESC_TYPE:   cfg_type  = pwdata;
                    default: ;
                endcase
            end

            if (byte_valid && byte_ready)
                parse_byte(data_byte);

            outstanding = pending_results.size();
        end
    end

endmodule

### test/journal_descriptor_tag_parser_core_tb.sv
// journal_descriptor_tag_parser_core_tb: drives descriptor blocks and register
// settings into the parser and reports the verdict from jdtp_tag_check.
// Depends on jdtp_pkg, jdtp_if, the parser core and jdtp_tag_check.

module journal_descriptor_tag_parser_core_tb;
    import jdtp_pkg::*;

    typedef enum int {
        SHAPE_GOOD,
        SHAPE_BAD_MAGIC,
        SHAPE_BAD_TYPE,
        SHAPE_NOISE
    } block_shape_t;

    localparam logic [2:0] REG_SPARE = 3'd7;
    localparam int IDLE_PCT      = 24;
    localparam int RANDOM_BYTES  = 350;
    localparam int SETTLE_CYCLES = 4;

    logic                  clk   = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [WORD_W-1:0]     pwdata;
    logic [WORD_W-1:0]     prdata;
    logic                  pready;
    int unsigned           mismatches;
    int unsigned           outstanding;
    bit                    quiet = 1'b0;
    int unsigned           small_bytes;

    // layout the stimulus generator builds blocks for
    int unsigned           gen_block = RST_BLOCK_BYTES;
    int unsigned           gen_tag   = RST_TAG_BYTES;
    bit                    gen_tail  = 1'b0;
    logic [WORD_W-1:0]     gen_magic = RST_MAGIC;
    logic [WORD_W-1:0]     gen_type  = RST_DESC_TYPE;
    logic [BYTE_W-1:0]     block_image [$];

    jdtp_byte_if   byte_ch ();
    jdtp_result_if res_ch ();

    journal_descriptor_tag_parser_core i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .bytes   (byte_ch),
        .results (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    jdtp_tag_check i_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_ch.valid),
        .byte_ready   (byte_ch.ready),
        .data_byte    (byte_ch.data_byte),
        .res_valid    (res_ch.valid),
        .res_ready    (res_ch.ready),
        .kind         (res_ch.kind),
        .fs_block     (res_ch.fs_block),
        .tag_position (res_ch.tag_position),
        .last_result  (res_ch.last_result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .mismatches   (mismatches),
        .outstanding  (outstanding)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // result side stalls at random
    always @(posedge clk)
        res_ch.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);

    // run limit
    initial
    begin
        #10_000_000;
        $display("status: fail");
        $finish;
    end

    // apb write: setup cycle, then access cycle until pready
    task automatic write_reg(input logic [2:0] idx, input logic [WORD_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_BLOCK_BYTES:
            begin
                gen_block = val[BLK_CFG_W-1:0];
                if (gen_block == 0)
                    gen_block = 1;
                if (gen_block > DEF_MAX_BLOCK_BYTES)
                    gen_block = DEF_MAX_BLOCK_BYTES;
            end
            REG_TAG_BYTES:
            begin
                if (val[TAG_CFG_W-1:0] == V3_TAG_BYTES)
                    gen_tag = V3_TAG_BYTES;
                else if (val[TAG_CFG_W-1:0] > SHORT_TAG_BYTES)
                    gen_tag = CLASSIC_TAG_BYTES;
                else
                    gen_tag = SHORT_TAG_BYTES;
            end
            REG_HAS_TAIL:  gen_tail  = val[0];
            REG_MAGIC:     gen_magic = val;
            REG_DESC_TYPE: gen_type  = val;
            default: ;
        endcase
    endtask

    // drop valid and wait for every predicted result word to drain
    task automatic settle();
        byte_ch.valid <= 1'b0;
        repeat (2) @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(input int unsigned blk, input int unsigned tag, input bit tail,
                              input logic [WORD_W-1:0] magic, input logic [WORD_W-1:0] typ);
        settle();
        write_reg(REG_BLOCK_BYTES, blk);
        write_reg(REG_TAG_BYTES, tag);
        write_reg(REG_HAS_TAIL, tail);
        write_reg(REG_MAGIC, magic);
        write_reg(REG_DESC_TYPE, typ);
    endtask

    // one byte word with a random gap in front
    task automatic push_byte(input logic [BYTE_W-1:0] b);
        while (!quiet && $urandom_range(99) < IDLE_PCT)
        begin
            byte_ch.valid <= 1'b0;
            @(posedge clk);
        end
        byte_ch.valid     <= 1'b1;
        byte_ch.data_byte <= b;
        do @(posedge clk); while (!byte_ch.ready);
    endtask

    task automatic send_span(input int from, input int upto);
        for (int i = from; i < upto; i++)
            push_byte(block_image[i]);
    endtask

    // block image: header, chained tags with random content, random filler
    function automatic void build_block(input block_shape_t shape);
        int unsigned      off;
        int unsigned      tail;
        int unsigned      limit;
        int unsigned      pos;
        logic [WORD_W-1:0] flags;
        logic [BYTE_W-1:0] ext;
        int unsigned      fill;

        block_image.delete();
        for (int i = 0; i < gen_block; i++)
            block_image.insert(block_image.size(), BYTE_W'($urandom));
        if (shape == SHAPE_NOISE)
            return;

        for (int i = 0; i < 4; i++)
        begin
            if (i < gen_block)
                block_image[i] = gen_magic[31-8*i -: 8];
            if (4 + i < gen_block)
                block_image[4+i] = gen_type[31-8*i -: 8];
        end
        if (shape != SHAPE_GOOD)
        begin
            pos = (shape == SHAPE_BAD_MAGIC) ? $urandom_range(3) : 4 + $urandom_range(3);
            if (pos < gen_block)
                block_image[pos] = block_image[pos] ^ BYTE_W'($urandom_range(1, 255));
        end

        tail  = gen_tail ? TAIL_BYTES : 0;
        limit = (gen_block > tail) ? gen_block - tail : 0;
        off   = HEADER_BYTES;
        while (off + gen_tag <= limit)
        begin
            // now and then an all-zero or all-one block number
            fill = $urandom_range(9);
            if (fill < 2)
            begin
                ext = (fill == 0) ? 8'h00 : 8'hFF;
                for (int j = 0; j < 4; j++)
                begin
                    block_image[off+j] = ext;
                    if (gen_tag != SHORT_TAG_BYTES)
                        block_image[off+8+j] = ext;
                end
            end
            flags = $urandom;
            if ($urandom_range(99) < 85)
                flags = flags | SAME_UUID_FLAG;
            else
                flags = flags & ~SAME_UUID_FLAG;
            if ($urandom_range(99) < 10)
                flags = flags | LAST_TAG_FLAG;
            else
                flags = flags & ~LAST_TAG_FLAG;
            if (gen_tag == V3_TAG_BYTES)
            begin
                for (int j = 0; j < 4; j++)
                    block_image[off+4+j] = flags[31-8*j -: 8];
            end
            else
            begin
                block_image[off+6] = flags[15:8];
                block_image[off+7] = flags[7:0];
            end
            if ((flags & LAST_TAG_FLAG) != 0)
                break;
            off = off + gen_tag + (((flags & SAME_UUID_FLAG) != 0) ? 0 : UUID_BYTES);
        end
    endfunction

    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(3))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic int unsigned pick_tag();
        case ($urandom_range(3))
            0:       return SHORT_TAG_BYTES;
            1:       return CLASSIC_TAG_BYTES;
            2:       return V3_TAG_BYTES;
            default: return $urandom_range(31);
        endcase
    endfunction

    function automatic block_shape_t pick_shape();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 70)
            return SHAPE_GOOD;
        else if (r < 80)
            return SHAPE_BAD_MAGIC;
        else if (r < 90)
            return SHAPE_BAD_TYPE;
        else
            return SHAPE_NOISE;
    endfunction

    // stimulus
    initial
    begin
        byte_ch.valid     <= 1'b0;
        byte_ch.data_byte <= '0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero block size acts as one byte: too small
        set_config(0, 0, 1'b0, RST_MAGIC, RST_DESC_TYPE);
        build_block(SHAPE_GOOD);
        send_span(0, block_image.size());

        // short tag ending on the final byte, then header mismatches
        set_config(20, SHORT_TAG_BYTES, 1'b0, RST_MAGIC, RST_DESC_TYPE);
        build_block(SHAPE_GOOD);
        send_span(0, block_image.size());
        build_block(SHAPE_BAD_MAGIC);
        send_span(0, block_image.size());
        build_block(SHAPE_BAD_TYPE);
        send_span(0, block_image.size());

        // checksum-v3 tag filling the block
        set_config(28, V3_TAG_BYTES, 1'b0, '0, '1);
        build_block(SHAPE_GOOD);
        send_span(0, block_image.size());

        // tail leaves no room for a tag
        set_config(24, 31, 1'b1, '1, '0);
        build_block(SHAPE_GOOD);
        send_span(0, block_image.size());

        // block size shrinks below the current offset within a block
        set_config(64, 9, 1'b0, RST_MAGIC, RST_DESC_TYPE);
        build_block(SHAPE_GOOD);
        send_span(0, 40);
        settle();
        write_reg(REG_BLOCK_BYTES, 30);
        send_span(40, 41);
        settle();
        write_reg(REG_SPARE, $urandom);

        // long stretch with no idling on either side
        quiet = 1'b1;
        set_config(128, CLASSIC_TAG_BYTES, 1'b1, RST_MAGIC, RST_DESC_TYPE);
        build_block(SHAPE_GOOD);
        send_span(0, block_image.size());
        quiet = 1'b0;

        // random settings with mostly small blocks
        small_bytes = 0;
        while (small_bytes < RANDOM_BYTES)
        begin
            set_config(($urandom_range(9) == 0) ? $urandom_range(1, 30) : $urandom_range(20, 80),
                       pick_tag(), $urandom_range(1), pick_word(), pick_word());
            repeat ($urandom_range(1, 3))
            begin
                build_block(pick_shape());
                send_span(0, block_image.size());
                small_bytes += block_image.size();
            end
        end

        // size field above the maximum, block cut short by a smaller size
        set_config(17'h1FFFF, V3_TAG_BYTES, 1'b0, RST_MAGIC, RST_DESC_TYPE);
        build_block(SHAPE_GOOD);
        send_span(0, 60);
        settle();
        write_reg(REG_BLOCK_BYTES, 40);
        send_span(60, 61);

        settle();
        if (mismatches == 0 && outstanding == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
